// ===== hdl/scpm_pkg.sv =====
package scpm_pkg;

    localparam int unsigned HALF_W = 16;
    localparam int unsigned CHIP_W = 2;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned BITCNT_W = 5;
    localparam int unsigned CFG_IDX_W = 2;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_CHIP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_CHIP     = 2'd2;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd50;
    localparam logic [CHIP_W-1:0] DAC_CHIP_RESET    = 2'd1;
    localparam logic [CHIP_W-1:0] TX_CHIP_RESET     = 2'd3;

    localparam logic [BITCNT_W-1:0] WRITE_BITS = 5'd16;
    localparam logic [BITCNT_W-1:0] READ_BITS  = 5'd8;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SETUP   = 7'b0000010,
        PH_TX_LOW  = 7'b0000100,
        PH_TX_HIGH = 7'b0001000,
        PH_RX_LOW  = 7'b0010000,
        PH_RX_HIGH = 7'b0100000,
        PH_CLOSE   = 7'b1000000
    } phase_t;

endpackage

// ===== hdl/serial_control_port_master_core.sv =====
// Serial control-port master for two codec chips sharing one serial clock and one
// data line, each with its own active-low select. Each input is a tick, a write or
// read start, or an unused code; each produces exactly one result transaction
// holding the pin levels after it, busy, done, reject and the last read byte.
// The block takes one transaction per clock cycle as long as the result side is
// ready: an input register feeds one stage of next-state logic that writes the
// protocol state and the result register together. Configuration must only be
// written while idle.
module serial_control_port_master_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic                                target,
    input  logic [scpm_pkg::ADDR_W-1:0]         reg_address,
    input  logic [scpm_pkg::BYTE_W-1:0]         write_data,
    input  logic                                serial_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                serial_clock,
    output logic                                serial_out,
    output logic                                dac_select_n,
    output logic                                tx_select_n,
    output logic                                busy_res,
    output logic                                transfer_done,
    output logic [scpm_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                rejected,
    input  logic                                cfg_write,
    input  logic [scpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scpm_pkg::HALF_W-1:0]         cfg_data
);
    import scpm_pkg::*;

    // Configuration.
    logic [HALF_W-1:0] half_period_reg;
    logic [CHIP_W-1:0] dac_chip_reg;
    logic [CHIP_W-1:0] tx_chip_reg;

    // Input register.
    logic              s1_valid_reg;
    logic [1:0]        s1_op_reg;
    logic              s1_target_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [BYTE_W-1:0] s1_wdata_reg;
    logic              s1_sin_reg;

    // Protocol state.
    phase_t              phase_reg, phase_next;
    logic [BITCNT_W-1:0] bit_count_reg, bit_count_next;
    logic [HALF_W-1:0]   tick_count_reg, tick_count_next;
    logic [FRAME_W-1:0]  frame_shift_reg, frame_shift_next;
    logic [BYTE_W-1:0]   capture_reg, capture_next;
    logic                active_target_reg, active_target_next;
    logic                read_mode_reg, read_mode_next;
    logic                clock_level_reg, clock_level_next;
    logic                data_level_reg, data_level_next;
    logic [1:0]          select_reg, select_next;

    // Result register.
    logic              out_valid_reg;
    logic              res_clock_reg;
    logic              res_data_reg;
    logic              res_dac_sel_reg;
    logic              res_tx_sel_reg;
    logic              res_busy_reg;
    logic              res_done_reg;
    logic [BYTE_W-1:0] res_read_reg;
    logic              res_rej_reg;

    logic              advance;
    logic              step;
    logic              done_next;
    logic              rej_next;
    logic [HALF_W:0]   tick_sum;
    logic [HALF_W-1:0] half_eff;
    logic [CHIP_W-1:0] chip_code;
    logic [BITCNT_W-1:0] bit_dec;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign step     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            dac_chip_reg    <= DAC_CHIP_RESET;
            tx_chip_reg     <= TX_CHIP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                CFG_DAC_CHIP:    dac_chip_reg    <= cfg_data[CHIP_W-1:0];
                CFG_TX_CHIP:     tx_chip_reg     <= cfg_data[CHIP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg     <= operation;
            s1_target_reg <= target;
            s1_addr_reg   <= reg_address;
            s1_wdata_reg  <= write_data;
            s1_sin_reg    <= serial_in;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        tick_count_next    = tick_count_reg;
        frame_shift_next   = frame_shift_reg;
        capture_next       = capture_reg;
        active_target_next = active_target_reg;
        read_mode_next     = read_mode_reg;
        clock_level_next   = clock_level_reg;
        data_level_next    = data_level_reg;
        select_next        = select_reg;
        done_next          = 1'b0;
        rej_next           = 1'b0;

        half_eff  = (half_period_reg == '0) ? HALF_W'(1) : half_period_reg;
        tick_sum  = {1'b0, tick_count_reg} + (HALF_W+1)'(1);
        chip_code = s1_target_reg ? tx_chip_reg : dac_chip_reg;
        bit_dec   = (bit_count_reg == '0) ? '0 : bit_count_reg - BITCNT_W'(1);

        if (s1_op_reg == OP_WRITE || s1_op_reg == OP_READ)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                active_target_next = s1_target_reg;
                read_mode_next     = (s1_op_reg == OP_READ);
                if (s1_op_reg == OP_READ)
                begin
                    frame_shift_next = {chip_code, 1'b0, s1_addr_reg, 8'h00};
                    bit_count_next   = READ_BITS;
                end
                else
                begin
                    frame_shift_next = {chip_code, 1'b1, s1_addr_reg, s1_wdata_reg};
                    bit_count_next   = WRITE_BITS;
                end
                clock_level_next = 1'b1;
                data_level_next  = 1'b1;
                select_next      = 2'b11;
                tick_count_next  = '0;
                phase_next       = PH_SETUP;
            end
        end
        else if (s1_op_reg == OP_TICK && phase_reg != PH_IDLE)
        begin
            if (tick_sum >= {1'b0, half_eff})
            begin
                tick_count_next = '0;
                case (phase_reg)
                    PH_SETUP:
                    begin
                        // Select the addressed chip and drive the first frame bit.
                        select_next      = active_target_reg ? 2'b01 : 2'b10;
                        clock_level_next = 1'b0;
                        data_level_next  = frame_shift_reg[FRAME_W-1];
                        frame_shift_next = {frame_shift_reg[FRAME_W-2:0], 1'b0};
                        phase_next       = PH_TX_LOW;
                    end
                    PH_TX_LOW:
                    begin
                        clock_level_next = 1'b1;
                        phase_next       = PH_TX_HIGH;
                    end
                    PH_TX_HIGH:
                    begin
                        bit_count_next = bit_dec;
                        if (bit_dec != '0)
                        begin
                            clock_level_next = 1'b0;
                            data_level_next  = frame_shift_reg[FRAME_W-1];
                            frame_shift_next = {frame_shift_reg[FRAME_W-2:0], 1'b0};
                            phase_next       = PH_TX_LOW;
                        end
                        else if (read_mode_reg)
                        begin
                            clock_level_next = 1'b0;
                            bit_count_next   = READ_BITS;
                            frame_shift_next = '0;
                            phase_next       = PH_RX_LOW;
                        end
                        else
                        begin
                            phase_next = PH_CLOSE;
                        end
                    end
                    PH_RX_LOW:
                    begin
                        clock_level_next = 1'b1;
                        frame_shift_next = {8'h00, frame_shift_reg[BYTE_W-2:0], s1_sin_reg};
                        phase_next       = PH_RX_HIGH;
                    end
                    PH_RX_HIGH:
                    begin
                        bit_count_next = bit_dec;
                        if (bit_dec != '0)
                        begin
                            clock_level_next = 1'b0;
                            phase_next       = PH_RX_LOW;
                        end
                        else
                        begin
                            capture_next = frame_shift_reg[BYTE_W-1:0];
                            phase_next   = PH_CLOSE;
                        end
                    end
                    default:
                    begin
                        clock_level_next = 1'b1;
                        data_level_next  = 1'b1;
                        select_next      = 2'b11;
                        bit_count_next   = '0;
                        phase_next       = PH_IDLE;
                        done_next        = 1'b1;
                    end
                endcase
            end
            else
            begin
                tick_count_next = tick_sum[HALF_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            tick_count_reg    <= '0;
            frame_shift_reg   <= '0;
            capture_reg       <= '0;
            active_target_reg <= 1'b0;
            read_mode_reg     <= 1'b0;
            clock_level_reg   <= 1'b1;
            data_level_reg    <= 1'b1;
            select_reg        <= 2'b11;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            tick_count_reg    <= tick_count_next;
            frame_shift_reg   <= frame_shift_next;
            capture_reg       <= capture_next;
            active_target_reg <= active_target_next;
            read_mode_reg     <= read_mode_next;
            clock_level_reg   <= clock_level_next;
            data_level_reg    <= data_level_next;
            select_reg        <= select_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_clock_reg   <= clock_level_next;
            res_data_reg    <= data_level_next;
            res_dac_sel_reg <= select_next[0];
            res_tx_sel_reg  <= select_next[1];
            res_busy_reg    <= (phase_next != PH_IDLE);
            res_done_reg    <= done_next;
            res_read_reg    <= capture_next;
            res_rej_reg     <= rej_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign serial_clock  = res_clock_reg;
    assign serial_out    = res_data_reg;
    assign dac_select_n  = res_dac_sel_reg;
    assign tx_select_n   = res_tx_sel_reg;
    assign busy_res      = res_busy_reg;
    assign transfer_done = res_done_reg;
    assign rx_byte       = res_read_reg;
    assign rejected      = res_rej_reg;

`ifndef SYNTH
    // A finished transfer is never also busy, and never rejected.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transfer_done |-> !busy_res && !rejected)
        else $error("done reported together with busy or reject");

    // At most one chip is ever selected.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(~select_reg))
        else $error("both chip selects low");

    // While idle all serial lines rest high.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> clock_level_reg && data_level_reg && select_reg == 2'b11)
        else $error("lines not idle high while idle");

    // An empty result register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // A reject leaves the protocol state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && rej_next |=> $stable(phase_reg) && $stable(frame_shift_reg))
        else $error("rejected start changed state");
`endif

endmodule

// ===== tb/serial_control_port_master_core_tb.sv =====
`timescale 1ns / 100ps

module serial_control_port_master_core_tb;

    import scpm_pkg::*;

    localparam logic [1:0]           OP_UNUSED        = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE        = 2'd3;
    localparam int                   CYCLE_LIMIT      = 400000;
    localparam int                   DRAIN_SLACK      = 8;
    localparam int                   RANDOM_PER_PHASE = 500;
    localparam int                   IDLE_PLAN [4]    = '{0, 53, 0, 37};
    localparam int                   STALL_PLAN [4]   = '{0, 0, 53, 37};

    typedef struct packed {
        logic [1:0]        op;
        logic              tgt;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
        logic              sin;
    } port_cmd_t;

    typedef struct packed {
        logic              sclk;
        logic              sdo;
        logic              dac_n;
        logic              tx_n;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rdata;
        logic              rej;
    } pin_snapshot_t;

    typedef struct packed {
        port_cmd_t     cmd;
        int unsigned   reps;
        logic          typed;
        pin_snapshot_t want;
        logic          go_fast;
    } directed_row_t;

    localparam pin_snapshot_t PINS_IDLE = '{sclk: 1'b1, sdo: 1'b1, dac_n: 1'b1, tx_n: 1'b1,
        busy: 1'b0, done: 1'b0, rdata: 8'h00, rej: 1'b0};
    localparam pin_snapshot_t PINS_SETUP = '{sclk: 1'b1, sdo: 1'b1, dac_n: 1'b1, tx_n: 1'b1,
        busy: 1'b1, done: 1'b0, rdata: 8'h00, rej: 1'b0};
    localparam pin_snapshot_t PINS_SETUP_REJ = '{sclk: 1'b1, sdo: 1'b1, dac_n: 1'b1,
        tx_n: 1'b1, busy: 1'b1, done: 1'b0, rdata: 8'h00, rej: 1'b1};

    // The half period is set to zero before the third row, so the write frame below
    // runs at one tick per half period and the random part picks it up while busy.
    localparam directed_row_t DIRECTED [7] = '{
        '{cmd: '{OP_TICK, 1'b0, 5'd0, 8'h00, 1'b0}, reps: 1, typed: 1'b1,
          want: PINS_IDLE, go_fast: 1'b0},
        '{cmd: '{OP_UNUSED, 1'b1, 5'd31, 8'hFF, 1'b1}, reps: 1, typed: 1'b1,
          want: PINS_IDLE, go_fast: 1'b0},
        '{cmd: '{OP_WRITE, 1'b0, 5'd31, 8'hFF, 1'b0}, reps: 1, typed: 1'b1,
          want: PINS_SETUP, go_fast: 1'b1},
        '{cmd: '{OP_WRITE, 1'b1, 5'd0, 8'h00, 1'b0}, reps: 1, typed: 1'b1,
          want: PINS_SETUP_REJ, go_fast: 1'b0},
        '{cmd: '{OP_READ, 1'b1, 5'd0, 8'h00, 1'b1}, reps: 1, typed: 1'b1,
          want: PINS_SETUP_REJ, go_fast: 1'b0},
        '{cmd: '{OP_UNUSED, 1'b0, 5'd0, 8'h00, 1'b0}, reps: 1, typed: 1'b1,
          want: PINS_SETUP, go_fast: 1'b0},
        '{cmd: '{OP_TICK, 1'b0, 5'd0, 8'h00, 1'b1}, reps: 18, typed: 1'b0,
          want: PINS_IDLE, go_fast: 1'b0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           operation = OP_TICK;
    logic                 target = 1'b0;
    logic [ADDR_W-1:0]    reg_address = '0;
    logic [BYTE_W-1:0]    write_data = '0;
    logic                 serial_in = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 serial_clock;
    logic                 serial_out;
    logic                 dac_select_n;
    logic                 tx_select_n;
    logic                 busy_res;
    logic                 transfer_done;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 rejected;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HALF_PERIOD;
    logic [HALF_W-1:0]    cfg_data = '0;

    serial_control_port_master_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .target        (target),
        .reg_address   (reg_address),
        .write_data    (write_data),
        .serial_in     (serial_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .serial_clock  (serial_clock),
        .serial_out    (serial_out),
        .dac_select_n  (dac_select_n),
        .tx_select_n   (tx_select_n),
        .busy_res      (busy_res),
        .transfer_done (transfer_done),
        .rx_byte       (rx_byte),
        .rejected      (rejected),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Predicted port state and configuration.
    logic [HALF_W-1:0]   cfg_half = HALF_PERIOD_RESET;
    logic [CHIP_W-1:0]   cfg_dac = DAC_CHIP_RESET;
    logic [CHIP_W-1:0]   cfg_tx = TX_CHIP_RESET;
    phase_t              port_phase = PH_IDLE;
    logic [BITCNT_W-1:0] bits_left = '0;
    logic [HALF_W-1:0]   tick_cnt = '0;
    logic [FRAME_W-1:0]  shifter = '0;
    logic [BYTE_W-1:0]   captured = '0;
    logic                sel_target = 1'b0;
    logic                read_mode = 1'b0;
    logic                sclk_lvl = 1'b1;
    logic                sdo_lvl = 1'b1;
    logic [1:0]          sel_lvl = 2'b11;

    pin_snapshot_t pending_pins [$];
    int            errors = 0;
    int            cycles = 0;
    int            sender_idle_pct = 0;
    int            stall_pct = 0;
    int            rx_style = 0;

    function automatic void shift_out_bit();
        sclk_lvl = 1'b0;
        sdo_lvl = shifter[FRAME_W-1];
        shifter = shifter << 1;
        port_phase = PH_TX_LOW;
    endfunction

    function automatic pin_snapshot_t advance_port(port_cmd_t c);
        pin_snapshot_t r;
        logic [CHIP_W-1:0] chip;
        logic [HALF_W-1:0] hp;
        r = '0;
        hp = (cfg_half == '0) ? 16'd1 : cfg_half;
        if (c.op == OP_WRITE || c.op == OP_READ) begin
            if (port_phase != PH_IDLE) begin
                r.rej = 1'b1;
            end
            else begin
                chip = c.tgt ? cfg_tx : cfg_dac;
                sel_target = c.tgt;
                read_mode = (c.op == OP_READ);
                if (read_mode) begin
                    shifter = {chip, 1'b0, c.addr, 8'h00};
                    bits_left = READ_BITS;
                end
                else begin
                    shifter = {chip, 1'b1, c.addr, c.wdata};
                    bits_left = WRITE_BITS;
                end
                sclk_lvl = 1'b1;
                sdo_lvl = 1'b1;
                sel_lvl = 2'b11;
                tick_cnt = '0;
                port_phase = PH_SETUP;
            end
        end
        else if (c.op == OP_TICK && port_phase != PH_IDLE) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= hp) begin
                tick_cnt = '0;
                case (port_phase)
                    PH_SETUP:
                    begin
                        sel_lvl = sel_target ? 2'b01 : 2'b10;
                        shift_out_bit();
                    end
                    PH_TX_LOW:
                    begin
                        sclk_lvl = 1'b1;
                        port_phase = PH_TX_HIGH;
                    end
                    PH_TX_HIGH:
                    begin
                        if (bits_left != '0) bits_left = bits_left - 1'b1;
                        if (bits_left != '0) begin
                            shift_out_bit();
                        end
                        else if (read_mode) begin
                            sclk_lvl = 1'b0;
                            bits_left = READ_BITS;
                            shifter = '0;
                            port_phase = PH_RX_LOW;
                        end
                        else begin
                            port_phase = PH_CLOSE;
                        end
                    end
                    PH_RX_LOW:
                    begin
                        // The slave bit is taken on the tick that raises the clock.
                        sclk_lvl = 1'b1;
                        shifter = {8'h00, shifter[6:0], c.sin};
                        port_phase = PH_RX_HIGH;
                    end
                    PH_RX_HIGH:
                    begin
                        if (bits_left != '0) bits_left = bits_left - 1'b1;
                        if (bits_left != '0) begin
                            sclk_lvl = 1'b0;
                            port_phase = PH_RX_LOW;
                        end
                        else begin
                            captured = shifter[BYTE_W-1:0];
                            port_phase = PH_CLOSE;
                        end
                    end
                    default:
                    begin
                        sclk_lvl = 1'b1;
                        sdo_lvl = 1'b1;
                        sel_lvl = 2'b11;
                        bits_left = '0;
                        port_phase = PH_IDLE;
                        r.done = 1'b1;
                    end
                endcase
            end
        end
        r.sclk = sclk_lvl;
        r.sdo = sdo_lvl;
        r.dac_n = sel_lvl[0];
        r.tx_n = sel_lvl[1];
        r.busy = (port_phase != PH_IDLE);
        r.rdata = captured;
        return r;
    endfunction

    // Mostly complete transfers with random content; the rest is rejected starts,
    // unused codes and ticks while idle. Read data is sometimes held all low or all high.
    function automatic port_cmd_t make_cmd();
        port_cmd_t c;
        int roll;
        c.tgt = 1'($urandom_range(1));
        c.addr = 5'($urandom_range(31));
        c.wdata = 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (port_phase == PH_IDLE) begin
            if (roll < 30) c.op = OP_WRITE;
            else if (roll < 60) c.op = OP_READ;
            else if (roll < 90) c.op = OP_TICK;
            else c.op = OP_UNUSED;
            if (roll < 60) rx_style = $urandom_range(2);
        end
        else begin
            if (roll < 92) c.op = OP_TICK;
            else if (roll < 95) c.op = OP_WRITE;
            else if (roll < 98) c.op = OP_READ;
            else c.op = OP_UNUSED;
        end
        case (rx_style)
            1: c.sin = 1'b0;
            2: c.sin = 1'b1;
            default: c.sin = 1'($urandom_range(1));
        endcase
        return c;
    endfunction

    // Entered and left just after a falling edge.
    task automatic issue_cmd(port_cmd_t c, logic typed, pin_snapshot_t want);
        pin_snapshot_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= c.op;
        target <= c.tgt;
        reg_address <= c.addr;
        write_data <= c.wdata;
        serial_in <= c.sin;
        do @(posedge clk); while (!in_ready);
        predicted = advance_port(c);
        pending_pins.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_pins.size() != 0);
    endtask

    task automatic quiesce();
        wait_results();
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic finish_transfer();
        port_cmd_t c;
        while (port_phase != PH_IDLE) begin
            c = make_cmd();
            c.op = OP_TICK;
            issue_cmd(c, 1'b0, '0);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_HALF_PERIOD: cfg_half = value;
            CFG_DAC_CHIP:    cfg_dac = value[CHIP_W-1:0];
            CFG_TX_CHIP:     cfg_tx = value[CHIP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                        logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin
        pin_snapshot_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pins.size() == 0) begin
                $display("%0t: result transaction with nothing expected", $time);
                errors++;
            end
            else begin
                want = pending_pins.pop_front();
                check_field("serial_clock", BYTE_W'(want.sclk), BYTE_W'(serial_clock));
                check_field("serial_out", BYTE_W'(want.sdo), BYTE_W'(serial_out));
                check_field("dac_select_n", BYTE_W'(want.dac_n), BYTE_W'(dac_select_n));
                check_field("tx_select_n", BYTE_W'(want.tx_n), BYTE_W'(tx_select_n));
                check_field("busy_res", BYTE_W'(want.busy), BYTE_W'(busy_res));
                check_field("transfer_done", BYTE_W'(want.done), BYTE_W'(transfer_done));
                check_field("rx_byte", want.rdata, rx_byte);
                check_field("rejected", BYTE_W'(want.rej), BYTE_W'(rejected));
            end
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        port_cmd_t c;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 7; i++) begin
            if (DIRECTED[i].go_fast) begin
                quiesce();
                write_reg(CFG_HALF_PERIOD, 16'd0);
            end
            repeat (DIRECTED[i].reps)
                issue_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                finish_transfer();
                quiesce();
                case (p)
                    1:
                    begin
                        write_reg(CFG_HALF_PERIOD, 16'd1);
                        write_reg(CFG_DAC_CHIP, {14'($urandom), 2'd0});
                        write_reg(CFG_TX_CHIP, {14'($urandom), 2'd2});
                    end
                    2:
                    begin
                        write_reg(CFG_HALF_PERIOD, 16'd2);
                        write_reg(CFG_DAC_CHIP, {14'($urandom), 2'd3});
                        write_reg(CFG_TX_CHIP, {14'($urandom), 2'd0});
                    end
                    default:
                    begin
                        write_reg(CFG_HALF_PERIOD, 16'd3);
                        write_reg(CFG_DAC_CHIP, {14'($urandom), 2'd2});
                        write_reg(CFG_TX_CHIP, {14'($urandom), 2'd1});
                        write_reg(CFG_SPARE, 16'hFFFF);
                    end
                endcase
            end
            sender_idle_pct = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Now and then hold the sender back until the output side is empty.
                if (n == RANDOM_PER_PHASE / 2 || $urandom_range(199) == 0)
                    wait_results();
                issue_cmd(make_cmd(), 1'b0, '0);
            end
        end

        // Longest half period: a transfer is opened and left running to the end.
        finish_transfer();
        quiesce();
        sender_idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_HALF_PERIOD, 16'hFFFF);
        c = make_cmd();
        c.op = OP_WRITE;
        issue_cmd(c, 1'b0, '0);
        for (int n = 0; n < 200; n++) begin
            c = make_cmd();
            if (n == 100) c.op = OP_READ;
            issue_cmd(c, 1'b0, '0);
        end

        quiesce();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== serial_control_port_master_core.f =====
hdl/scpm_pkg.sv
hdl/serial_control_port_master_core.sv
tb/serial_control_port_master_core_tb.sv
